// ----- hdl/lnhl_pkg.sv -----
// Shared constants for the parallel-port nibble handshake link.
// Holds command and status codes and the handshake timer sizing; no dependencies.
package lnhl_pkg;

  localparam int unsigned TIMER_BITS   = 24;
  localparam int unsigned TIMEOUT_BITS = 24;
  localparam int unsigned CMP_BITS     = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS
                                                                     : TIMEOUT_BITS;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(200000);
  localparam logic [TIMER_BITS-1:0]   COUNT_MAX     = {TIMER_BITS{1'b1}};

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;
  localparam logic [1:0] STAT_REJECT  = 2'd3;

endpackage

// ----- hdl/lnhl_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
// Standalone; used by the link top level.
interface lnhl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] host_lines;
  logic [7:0] write_data;

  modport source (output valid, cmd, host_lines, write_data, input ready);
  modport sink (input valid, cmd, host_lines, write_data, output ready);
endinterface

interface lnhl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_lines;
  logic       ack_line;
  logic [7:0] read_byte;
  logic [1:0] status;
  logic       host_ready;
  logic       busy_res;

  modport source (output valid, data_lines, ack_line, read_byte, status, host_ready,
                  busy_res, input ready);
  modport sink (input valid, data_lines, ack_line, read_byte, status, host_ready,
                busy_res, output ready);
endinterface

// ----- hdl/lpt_nibble_handshake_link.sv -----
// Top level of the parallel-port nibble handshake link.
// Depends on lnhl_pkg and the channel interfaces in lnhl_if.sv.
//
// The link accepts one command beat per clock and returns exactly one result
// beat for each, registered in the single result register and shown in the
// cycle after acceptance; a new beat is taken whenever that register is empty or
// being drained in the same cycle. Tick beats carry the pin sample that drives
// each handshake wait, and the wait timeout counts waiting tick beats against
// the timeout register, which should be written only while the link is idle.
module lpt_nibble_handshake_link (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lnhl_pkg::TIMEOUT_BITS-1:0]   cfg_wdata_i,
  lnhl_in_if.sink                             in_i,
  lnhl_out_if.source                          res_o
);
  import lnhl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RD_HI,
    PH_RD_LO,
    PH_WR_HI,
    PH_WR_LO
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [TIMER_BITS-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [7:0]              hold_q, hold_d;
  logic [3:0]              drive_q, drive_d;
  logic                    ack_q, ack_d;
  logic [TIMEOUT_BITS-1:0] timeout_q, limit;
  logic                    res_valid_q;
  logic [3:0]              res_data_q;
  logic                    res_ack_q;
  logic [7:0]              res_byte_q, rbyte;
  logic [1:0]              res_stat_q, status;
  logic                    res_ready_q;
  logic                    res_busy_q;
  logic [4:0]              st;
  logic                    ready, expired, accept;

  assign in_i.ready = !res_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign st      = {in_i.host_lines[0], in_i.host_lines[1], in_i.host_lines[2],
                    in_i.host_lines[3], in_i.host_lines[4]};
  assign ready   = st[4];
  assign limit   = (timeout_q == '0) ? TIMEOUT_BITS'(1) : timeout_q;
  assign cnt_inc = (cnt_q != COUNT_MAX) ? cnt_q + TIMER_BITS'(1) : cnt_q;
  assign expired = CMP_BITS'(cnt_inc) >= CMP_BITS'(limit);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    drive_d = drive_q;
    ack_d   = ack_q;
    status  = STAT_NONE;
    rbyte   = 8'h00;
    if (in_i.cmd == CMD_READ || in_i.cmd == CMD_WRITE) begin
      if (phase_q != PH_IDLE) begin
        status = STAT_REJECT;
      end else if (in_i.cmd == CMD_READ) begin
        phase_d = PH_RD_HI;
        cnt_d   = '0;
      end else begin
        hold_d  = in_i.write_data;
        drive_d = ~in_i.write_data[7:4];
        ack_d   = 1'b1;
        phase_d = PH_WR_HI;
        cnt_d   = '0;
      end
    end else begin
      case (phase_q)
        PH_RD_HI: begin
          if (!ready) begin
            cnt_d = cnt_inc;
            if (expired) begin
              ack_d   = 1'b0;
              phase_d = PH_IDLE;
              status  = STAT_TIMEOUT;
            end
          end else begin
            hold_d  = {st[3:0], 4'h0};
            ack_d   = 1'b1;
            phase_d = PH_RD_LO;
            cnt_d   = '0;
          end
        end
        PH_RD_LO: begin
          if (ready) begin
            cnt_d = cnt_inc;
            if (expired) begin
              phase_d = PH_IDLE;
              status  = STAT_TIMEOUT;
            end
          end else begin
            hold_d  = {hold_q[7:4], st[3:0]};
            ack_d   = 1'b0;
            phase_d = PH_IDLE;
            status  = STAT_OK;
            rbyte   = {hold_q[7:4], st[3:0]};
          end
        end
        PH_WR_HI: begin
          if (!ready) begin
            cnt_d = cnt_inc;
            if (expired) begin
              ack_d   = 1'b0;
              phase_d = PH_IDLE;
              status  = STAT_TIMEOUT;
            end
          end else begin
            drive_d = ~hold_q[3:0];
            ack_d   = 1'b0;
            phase_d = PH_WR_LO;
            cnt_d   = '0;
          end
        end
        PH_WR_LO: begin
          if (ready) begin
            cnt_d = cnt_inc;
            if (expired) begin
              ack_d   = 1'b0;
              phase_d = PH_IDLE;
              status  = STAT_TIMEOUT;
            end
          end else begin
            phase_d = PH_IDLE;
            status  = STAT_OK;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      hold_q      <= 8'h00;
      drive_q     <= 4'hF;
      ack_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        hold_q      <= hold_d;
        drive_q     <= drive_d;
        ack_q       <= ack_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_data_q  <= drive_d;
      res_ack_q   <= ack_d;
      res_byte_q  <= rbyte;
      res_stat_q  <= status;
      res_ready_q <= ready;
      res_busy_q  <= (phase_d != PH_IDLE);
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.data_lines = res_data_q;
  assign res_o.ack_line   = res_ack_q;
  assign res_o.read_byte  = res_byte_q;
  assign res_o.status     = res_stat_q;
  assign res_o.host_ready = res_ready_q;
  assign res_o.busy_res   = res_busy_q;

endmodule

// ----- hdl/lnhl_checker.sv -----
// Port-level assertions for the nibble handshake link, bound to its top level.
// Depends on lnhl_pkg for the status codes.
module lnhl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [3:0] data_lines_i,
  input logic       ack_line_i,
  input logic [7:0] read_byte_i,
  input logic [1:0] status_i,
  input logic       busy_res_i
);
  import lnhl_pkg::*;

  // A stalled result beat must hold its contents until taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(data_lines_i)
      && $stable(ack_line_i) && $stable(read_byte_i) && $stable(status_i))
    else $error("result beat changed while stalled");

  a_ready_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> res_valid_i)
    else $error("input stalled with no pending result");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == STAT_OK || status_i == STAT_TIMEOUT) |-> !busy_res_i)
    else $error("transfer still busy after it ended");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == STAT_REJECT |-> busy_res_i)
    else $error("start rejected while link idle");

  a_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && read_byte_i != 8'h00 |-> status_i == STAT_OK && !ack_line_i)
    else $error("read byte reported without a completed read");

endmodule

bind lpt_nibble_handshake_link lnhl_checker u_lnhl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .data_lines_i (res_o.data_lines),
  .ack_line_i   (res_o.ack_line),
  .read_byte_i  (res_o.read_byte),
  .status_i     (res_o.status),
  .busy_res_i   (res_o.busy_res)
);

// ----- verif/lpt_nibble_handshake_link_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lpt_nibble_handshake_link: directed and random nibble transfers.
// A local model predicts every result beat. Depends on lnhl_pkg and the channel interfaces.
module lpt_nibble_handshake_link_tb;
  import lnhl_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    LINK_IDLE, LINK_RD_HI, LINK_RD_LO, LINK_WR_HI, LINK_WR_LO
  } link_phase_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] host_lines;
    logic [7:0] write_data;
  } port_beat_t;

  typedef struct packed {
    logic [3:0] data_lines;
    logic       ack_line;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       host_ready;
    logic       busy_res;
  } link_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [TIMEOUT_BITS-1:0] cfg_wdata = '0;

  lnhl_in_if  in_if ();
  lnhl_out_if res_if ();

  lpt_nibble_handshake_link DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if.sink),
    .res_o       (res_if.source)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the link state.
  link_phase_e             link_phase = LINK_IDLE;
  logic [TIMER_BITS-1:0]   wait_cnt = '0;
  logic [7:0]              byte_hold = '0;
  logic [3:0]              drive_nib = 4'hF;
  logic                    ack_lvl = 1'b0;
  logic [TIMEOUT_BITS-1:0] timeout_limit = TIMEOUT_RESET;

  port_beat_t beats_to_send[$];
  link_res_t  results_due[$];
  bit         beat_taken = 0;
  bit         quiet = 0;
  int         send_gap = 0;
  int         sink_stall = 0;
  int         errors = 0;
  int         cycles = 0;
  int         n_beats = 0;
  int         n_ok = 0;
  int         n_timeout = 0;
  int         n_reject = 0;

  function automatic logic wait_expired();
    logic [TIMER_BITS-1:0] lim;
    lim = (timeout_limit == '0) ? TIMER_BITS'(1) : TIMER_BITS'(timeout_limit);
    if (wait_cnt != COUNT_MAX) wait_cnt++;
    return wait_cnt >= lim;
  endfunction

  function automatic link_res_t predict_link(port_beat_t b);
    link_res_t  r;
    logic       rdy;
    logic [3:0] nib;
    rdy = b.host_lines[0];
    nib = {b.host_lines[1], b.host_lines[2], b.host_lines[3], b.host_lines[4]};
    r.status = STAT_NONE;
    r.read_byte = 8'h00;
    if (b.cmd == CMD_READ || b.cmd == CMD_WRITE) begin
      if (link_phase != LINK_IDLE) begin
        r.status = STAT_REJECT;
      end else if (b.cmd == CMD_READ) begin
        link_phase = LINK_RD_HI;
        wait_cnt = '0;
      end else begin
        byte_hold = b.write_data;
        drive_nib = ~b.write_data[7:4];
        ack_lvl = 1'b1;
        link_phase = LINK_WR_HI;
        wait_cnt = '0;
      end
    end else begin
      case (link_phase)
        LINK_RD_HI: begin
          if (!rdy) begin
            if (wait_expired()) begin
              ack_lvl = 1'b0;
              link_phase = LINK_IDLE;
              r.status = STAT_TIMEOUT;
            end
          end else begin
            byte_hold = {nib, 4'h0};
            ack_lvl = 1'b1;
            link_phase = LINK_RD_LO;
            wait_cnt = '0;
          end
        end
        LINK_RD_LO: begin
          if (rdy) begin
            if (wait_expired()) begin
              link_phase = LINK_IDLE;
              r.status = STAT_TIMEOUT;
            end
          end else begin
            byte_hold = {byte_hold[7:4], nib};
            ack_lvl = 1'b0;
            link_phase = LINK_IDLE;
            r.status = STAT_OK;
            r.read_byte = byte_hold;
          end
        end
        LINK_WR_HI: begin
          if (!rdy) begin
            if (wait_expired()) begin
              ack_lvl = 1'b0;
              link_phase = LINK_IDLE;
              r.status = STAT_TIMEOUT;
            end
          end else begin
            drive_nib = ~byte_hold[3:0];
            ack_lvl = 1'b0;
            link_phase = LINK_WR_LO;
            wait_cnt = '0;
          end
        end
        LINK_WR_LO: begin
          if (rdy) begin
            if (wait_expired()) begin
              ack_lvl = 1'b0;
              link_phase = LINK_IDLE;
              r.status = STAT_TIMEOUT;
            end
          end else begin
            link_phase = LINK_IDLE;
            r.status = STAT_OK;
          end
        end
        default: link_phase = LINK_IDLE;
      endcase
    end
    r.data_lines = drive_nib;
    r.ack_line = ack_lvl;
    r.host_ready = rdy;
    r.busy_res = (link_phase != LINK_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endfunction

  // Beat driver: presents the next pending beat after the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || beat_taken) begin
      port_beat_t b;
      beat_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_if.valid <= 1'b0;
      end else if (beats_to_send.size() > 0) begin
        b = beats_to_send.pop_front();
        in_if.cmd <= b.cmd;
        in_if.host_lines <= b.host_lines;
        in_if.write_data <= b.write_data;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink with random stall bursts.
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall--;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      sink_stall = $urandom_range(0, 3);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: checks result beats, then predicts for each accepted command beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        link_res_t e;
        if (results_due.size() == 0) begin
          $error("result beat with no expectation pending");
          errors++;
        end else begin
          e = results_due.pop_front();
          n_beats++;
          if (e.status == STAT_OK) n_ok++;
          if (e.status == STAT_TIMEOUT) n_timeout++;
          if (e.status == STAT_REJECT) n_reject++;
          check_field("data_lines", 32'(e.data_lines), 32'(res_if.data_lines));
          check_field("ack_line", 32'(e.ack_line), 32'(res_if.ack_line));
          check_field("read_byte", 32'(e.read_byte), 32'(res_if.read_byte));
          check_field("status", 32'(e.status), 32'(res_if.status));
          check_field("host_ready", 32'(e.host_ready), 32'(res_if.host_ready));
          check_field("busy_res", 32'(e.busy_res), 32'(res_if.busy_res));
        end
      end
      if (in_if.valid && in_if.ready) begin
        results_due.push_back(predict_link({in_if.cmd, in_if.host_lines, in_if.write_data}));
        beat_taken = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [4:0] pins(logic rdy, logic [3:0] nib);
    return {nib[0], nib[1], nib[2], nib[3], rdy};
  endfunction

  task automatic send(logic [1:0] cmd, logic [4:0] host, logic [7:0] wdata);
    beats_to_send.push_back({cmd, host, wdata});
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || in_if.valid || results_due.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // Completes any open transfer so the link is idle before a register write.
  task automatic settle_idle();
    drain();
    while (link_phase != LINK_IDLE) begin
      send(CMD_TICK, pins(link_phase inside {LINK_RD_HI, LINK_WR_HI}, 4'($urandom)),
           8'($urandom));
      drain();
    end
  endtask

  task automatic set_timeout(logic [TIMEOUT_BITS-1:0] v);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    timeout_limit = v;
  endtask

  task automatic random_xfer();
    logic       wr;
    int         stalls;
    logic [1:0] c;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send(2'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
      end
      return;
    end
    wr = 1'($urandom_range(0, 1));
    send(wr ? CMD_WRITE : CMD_READ, 5'($urandom), 8'($urandom));
    for (int w = 0; w < 2; w++) begin
      stalls = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
      repeat (stalls) begin
        if ($urandom_range(0, 9) == 0) begin
          send($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 5'($urandom), 8'($urandom));
        end else begin
          c = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_TICK;
          send(c, pins(w == 1, 4'($urandom)), 8'($urandom));
        end
      end
      send(CMD_TICK, pins(w == 0, 4'($urandom)), 8'($urandom));
    end
  endtask

  initial begin
    logic [TIMEOUT_BITS-1:0] phase_limits[5];
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.host_lines = '0;
    in_if.write_data = '0;
    res_if.ready = 1'b0;
    phase_limits = '{TIMEOUT_BITS'(5), {TIMEOUT_BITS{1'b1}}, TIMEOUT_BITS'(1),
                     TIMEOUT_BITS'(12), TIMEOUT_BITS'(3)};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle ticks, the spare code, full transfers and a rejected start at the reset timeout.
    send(CMD_TICK, 5'h00, 8'h00);
    send(CMD_TICK, 5'h1F, 8'hFF);
    send(CMD_SPARE, 5'h00, 8'h00);
    send(CMD_READ, 5'h1F, 8'hFF);
    send(CMD_TICK, pins(1'b0, 4'hF), 8'h00);
    send(CMD_TICK, pins(1'b1, 4'hA), 8'h00);
    send(CMD_WRITE, 5'h00, 8'h3C);
    send(CMD_TICK, pins(1'b1, 4'h0), 8'h00);
    send(CMD_TICK, pins(1'b0, 4'h5), 8'h00);
    send(CMD_WRITE, 5'h00, 8'hFF);
    send(CMD_TICK, pins(1'b0, 4'h0), 8'h00);
    send(CMD_TICK, pins(1'b1, 4'hF), 8'h00);
    send(CMD_TICK, pins(1'b1, 4'hF), 8'h00);
    send(CMD_TICK, pins(1'b0, 4'h0), 8'h00);
    send(CMD_WRITE, 5'h1F, 8'h00);
    send(CMD_READ, 5'h00, 8'h00);
    send(CMD_TICK, pins(1'b1, 4'h3), 8'h00);
    send(CMD_TICK, pins(1'b0, 4'hC), 8'h00);
    send(CMD_READ, 5'h00, 8'h00);
    send(CMD_TICK, pins(1'b1, 4'hF), 8'h00);
    send(CMD_TICK, pins(1'b0, 4'h0), 8'h00);

    // A timeout on each of the four waits, then a zero limit acting as one.
    set_timeout(TIMEOUT_BITS'(1));
    send(CMD_READ, 5'h00, 8'h00);
    send(CMD_TICK, pins(1'b0, 4'h1), 8'h00);
    send(CMD_READ, 5'h00, 8'h00);
    send(CMD_TICK, pins(1'b1, 4'h8), 8'h00);
    send(CMD_TICK, pins(1'b1, 4'h8), 8'h00);
    send(CMD_WRITE, 5'h00, 8'h96);
    send(CMD_TICK, pins(1'b0, 4'h0), 8'h00);
    send(CMD_WRITE, 5'h00, 8'h69);
    send(CMD_TICK, pins(1'b1, 4'h0), 8'h00);
    send(CMD_TICK, pins(1'b1, 4'h0), 8'h00);
    set_timeout(TIMEOUT_BITS'(0));
    send(CMD_READ, 5'h00, 8'h00);
    send(CMD_TICK, pins(1'b0, 4'h7), 8'h00);

    for (int p = 0; p < 5; p++) begin
      set_timeout(phase_limits[p]);
      quiet = (p == 4);
      repeat (14) random_xfer();
    end

    drain();
    repeat (4) @(negedge clk_i);
    $display("Checked %0d result beats: %0d transfers done, %0d timeouts, %0d rejected starts.",
             n_beats, n_ok, n_timeout, n_reject);
    $display("Timeout limits covered zero, one, small values, the reset value and the maximum.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
